// File: rtl/rpcfd_pkg.sv
// Package for the frame deframer: status codes and register indexes.
// Used by rpc_frame_deframer_core and its testbench; depends on nothing.
`timescale 1ns / 1ps
package rpcfd_pkg;
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ID_LEN   = 3'd1;
  localparam logic [2:0] ST_METHOD   = 3'd2;
  localparam logic [2:0] ST_ERR_CODE = 3'd3;
  localparam logic [2:0] ST_INFO     = 3'd4;
  localparam logic [2:0] ST_DATA_NEG = 3'd5;

  localparam logic [7:0] START_RESET = 8'd2;
  localparam logic [7:0] END_RESET   = 8'd3;
endpackage

// File: rtl/rpc_frame_deframer_core.sv
// Top level of the frame deframer: byte window, candidate scanner and header parser.
// Depends on rpcfd_pkg and rpcfd_window.
`timescale 1ns / 1ps
// Each accepted byte is stored in a circular window, then a sequencer scans the
// buffered bytes oldest first through the single read port of the window memory.
// A position that is not a start marker costs one byte read; a start marker adds reads
// of the length word and end byte (no end byte if its length is out of range), and a
// matching frame adds the header words and then waits in S_OUT until the descriptor is
// taken. The input is not ready for a new byte until the scan of the last one is done,
// set by the one memory read port that every lookup goes through. No clearing pass is
// needed.
module rpc_frame_deframer_core
  import rpcfd_pkg::*;
#(
  parameter int WINDOW = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         frame_offset,
  output logic [10:0]        frame_len,
  output logic [10:0]        id_len,
  output logic [10:0]        method_len,
  output logic signed [31:0] error_code,
  output logic [10:0]        info_len,
  output logic [10:0]        data_len,
  output logic [2:0]         status
);
  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = CW + 2;
  localparam logic [SW-1:0] WIN_S = SW'(WINDOW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_CHK_S = 4'd3;
  localparam logic [3:0] S_CHK_L = 4'd4;
  localparam logic [3:0] S_CHK_E = 4'd5;
  localparam logic [3:0] S_P_ID  = 4'd6;
  localparam logic [3:0] S_G_ID  = 4'd7;
  localparam logic [3:0] S_G_ME  = 4'd8;
  localparam logic [3:0] S_G_ER  = 4'd9;
  localparam logic [3:0] S_G_IN  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    state, ret;
  logic [7:0]    start_marker, end_marker;
  logic [AW-1:0] read_pointer, write_pointer;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] scan_idx, base, pos, flen;
  logic [2:0]    cnt, nbytes;
  logic [31:0]   acc;
  logic [CW-1:0] idl, mel, inl, dl;
  logic [31:0]   err;
  logic [2:0]    st;
  logic [AW-1:0] off;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [33:0]   lenw, tmp_pos, dl_s;
  logic [SW-1:0] end_rel;

  // Reduce a sum below twice the window to a store position.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
    logic [SW-1:0] y;
    y = (x >= WIN_S) ? x - WIN_S : x;
    return y[AW-1:0];
  endfunction

  // Clamp a signed 32-bit length to the range zero to the window size.
  function automatic logic [CW-1:0] clamp(input logic [31:0] v);
    logic [CW-1:0] r;
    if (v[31]) r = '0;
    else if ({2'b00, v} > 34'(WINDOW)) r = CW'(WINDOW);
    else r = v[CW-1:0];
    return r;
  endfunction

  rpcfd_window #(.WINDOW(WINDOW), .AW(AW)) u_window (
    .clk(clk), .wr_en(wr_en), .wr_addr(write_pointer), .wr_data(rx_byte),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign wr_en    = in_valid && in_ready;
  assign rd_addr  = wrap(SW'(read_pointer) + SW'(base) + SW'(cnt));
  assign out_valid = (state == S_OUT);

  // Wide temporaries for the header field fit checks.
  always_comb begin
    lenw    = {2'b00, acc};
    tmp_pos = 34'(pos) + 34'd4 + lenw;
    end_rel = SW'(scan_idx) + SW'(acc[CW-1:0]) - SW'(1);
    dl_s    = 34'(flen) - 34'(pos) - 34'd9 - 34'(inl);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_RESET;
      end_marker   <= END_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_START_MARKER) start_marker <= cfg_data;
      else if (cfg_index == REG_END_MARKER) end_marker <= cfg_data;
    end
  end

  // Scan and parse sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (wr_en) begin
            write_pointer <= wrap(SW'(write_pointer) + SW'(1));
            if (fill_count == CW'(WINDOW)) begin
              read_pointer <= wrap(SW'(read_pointer) + SW'(1));
            end else begin
              fill_count <= fill_count + CW'(1);
            end
            scan_idx <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (SW'(scan_idx) + SW'(5) > SW'(fill_count)) begin
            state <= S_IDLE;
          end else begin
            base <= scan_idx; nbytes <= 3'd1; cnt <= '0;
            ret <= S_CHK_S; state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (cnt != 3'd0) acc <= {acc[23:0], rd_data};
          if (cnt == nbytes) state <= ret;
          else cnt <= cnt + 3'd1;
        end
        S_CHK_S: begin
          if (acc[7:0] != start_marker) begin
            scan_idx <= scan_idx + CW'(1); state <= S_SCAN;
          end else begin
            base <= scan_idx + CW'(1); nbytes <= 3'd4; cnt <= '0;
            ret <= S_CHK_L; state <= S_FETCH;
          end
        end
        S_CHK_L: begin
          if (acc < 32'd2 || lenw > 34'(WINDOW) || end_rel >= SW'(fill_count)) begin
            scan_idx <= scan_idx + CW'(1); state <= S_SCAN;
          end else begin
            flen <= acc[CW-1:0];
            base <= end_rel[CW-1:0]; nbytes <= 3'd1; cnt <= '0;
            ret <= S_CHK_E; state <= S_FETCH;
          end
        end
        S_CHK_E: begin
          if (acc[7:0] != end_marker) begin
            scan_idx <= scan_idx + CW'(1); state <= S_SCAN;
          end else begin
            off <= wrap(SW'(read_pointer) + SW'(scan_idx));
            idl <= '0; mel <= '0; inl <= '0; err <= '0; dl <= '0;
            st <= ST_OK; pos <= CW'(5); state <= S_P_ID;
          end
        end
        S_P_ID: begin
          if (SW'(pos) + SW'(5) > SW'(flen)) begin
            st <= ST_ID_LEN; state <= S_FIN;
          end else begin
            base <= scan_idx + pos; nbytes <= 3'd4; cnt <= '0;
            ret <= S_G_ID; state <= S_FETCH;
          end
        end
        S_G_ID, S_G_ME: begin
          if (state == S_G_ID) idl <= clamp(acc);
          else mel <= clamp(acc);
          if (acc[31] || tmp_pos + 34'd5 > 34'(flen)) begin
            st <= (state == S_G_ID) ? ST_METHOD : ST_ERR_CODE;
            state <= S_FIN;
          end else begin
            pos <= tmp_pos[CW-1:0];
            base <= scan_idx + tmp_pos[CW-1:0]; nbytes <= 3'd4; cnt <= '0;
            ret <= (state == S_G_ID) ? S_G_ME : S_G_ER; state <= S_FETCH;
          end
        end
        S_G_ER: begin
          err <= acc;
          pos <= pos + CW'(4);
          if (SW'(pos) + SW'(9) > SW'(flen)) begin
            st <= ST_INFO; state <= S_FIN;
          end else begin
            base <= scan_idx + pos + CW'(4); nbytes <= 3'd4; cnt <= '0;
            ret <= S_G_IN; state <= S_FETCH;
          end
        end
        S_G_IN: begin
          inl <= clamp(acc);
          if (acc[31]) st <= ST_INFO;
          state <= S_FIN;
        end
        S_FIN: begin
          if (st == ST_OK) begin
            if (dl_s[33]) st <= ST_DATA_NEG;
            else dl <= dl_s[CW-1:0];
          end
          read_pointer <= wrap(SW'(read_pointer) + SW'(scan_idx) + SW'(flen));
          fill_count   <= fill_count - scan_idx - flen;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Descriptor outputs.
  assign frame_offset = 10'(off);
  assign frame_len    = 11'(flen);
  assign id_len       = 11'(idl);
  assign method_len   = 11'(mel);
  assign error_code   = err;
  assign info_len     = 11'(inl);
  assign data_len     = 11'(dl);
  assign status       = st;

  // The buffered count never exceeds the window.
  assert property (@(posedge clk) disable iff (rst) fill_count <= CW'(WINDOW))
    else $error("fill count above window");
  // A request is never taken while a descriptor is pending.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while descriptor pending");
  // After a byte is stored the window is not empty.
  assert property (@(posedge clk) disable iff (rst) wr_en |=> fill_count != '0)
    else $error("empty window after write");
  // A descriptor never reports a frame longer than the window.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flen >= CW'(2) && flen <= CW'(WINDOW)))
    else $error("frame length out of range");
endmodule

// File: rtl/rpcfd_window.sv
// Byte window store of the deframer: one write port, one registered read port.
// Does not depend on rpcfd_pkg; no types are shared.
`timescale 1ns / 1ps
module rpcfd_window #(
  parameter int WINDOW = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  logic [7:0] mem [WINDOW];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: tb/rpc_frame_deframer_core_tb.sv
// Testbench for rpc_frame_deframer_core: directed and random byte streams with a
// built-in frame predictor. Depends on rpcfd_pkg and the deframer RTL.
`timescale 1ns / 1ps
module rpc_frame_deframer_core_tb;
  import rpcfd_pkg::*;

  localparam int WIN = 1024;
  // Worst scan of a full window plus header parsing, with margin.
  localparam int DRAIN_CYCLES = 13 * WIN + 200;

  typedef struct packed {
    logic [9:0]  offset;
    logic [10:0] flen;
    logic [10:0] idl;
    logic [10:0] mel;
    logic [31:0] err;
    logic [10:0] inl;
    logic [10:0] dl;
    logic [2:0]  st;
  } frame_desc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] frame_offset;
  logic [10:0] frame_len, id_len, method_len, info_len, data_len;
  logic signed [31:0] error_code;
  logic [2:0] status;

  rpc_frame_deframer_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_offset(frame_offset), .frame_len(frame_len), .id_len(id_len),
    .method_len(method_len), .error_code(error_code), .info_len(info_len),
    .data_len(data_len), .status(status)
  );

  // Predictor state.
  logic [7:0] win_mem [WIN];
  int unsigned rd_ptr, wr_ptr, fill;
  logic [7:0] start_mk = START_RESET;
  logic [7:0] end_mk = END_RESET;

  frame_desc_t pending_frames[$];
  logic [7:0] stream_q[$];
  int fail_count = 0;
  int bytes_sent = 0;
  int frames_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("rpc_frame_deframer_core_tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] byte_at(int unsigned rel);
    return win_mem[(rd_ptr + rel) % WIN];
  endfunction

  function automatic logic [31:0] word_at(int unsigned rel);
    return {byte_at(rel), byte_at(rel + 1), byte_at(rel + 2), byte_at(rel + 3)};
  endfunction

  function automatic logic [10:0] clamp_len(longint v);
    if (v < 0) return 11'd0;
    if (v > WIN) return 11'(WIN);
    return 11'(v);
  endfunction

  // Stores one byte and searches the window for a completed frame.
  function automatic bit predict_frame(logic [7:0] b, output frame_desc_t d);
    int unsigned i;
    int unsigned len;
    longint e, pos, idl, mel, inl, err, dl;
    logic [2:0] st;
    bit hit;
    hit = 1'b0;
    len = 0;
    idl = 0; mel = 0; inl = 0; err = 0; dl = 0;
    st = ST_OK;
    d = '0;
    if (fill >= WIN) begin
      rd_ptr = (rd_ptr + 1) % WIN;
      fill = WIN - 1;
    end
    win_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % WIN;
    fill++;
    for (i = 0; i + 5 <= fill; i++) begin
      if (byte_at(i) == start_mk) begin
        len = word_at(i + 1);
        if (len >= 2 && len <= WIN && i + len - 1 < fill &&
            byte_at(i + len - 1) == end_mk) begin
          hit = 1'b1;
          break;
        end
      end
    end
    if (!hit) return 1'b0;

    // Walk the header fields; each must end before the end marker.
    e = longint'(len) - 1;
    pos = 5;
    if (pos + 4 > e) begin
      st = ST_ID_LEN;
    end else begin
      idl = longint'($signed(word_at(i + int'(pos))));
      pos = pos + 4 + idl;
      if (idl < 0 || pos + 4 > e) begin
        st = ST_METHOD;
      end else begin
        mel = longint'($signed(word_at(i + int'(pos))));
        pos = pos + 4 + mel;
        if (mel < 0 || pos + 4 > e) begin
          st = ST_ERR_CODE;
        end else begin
          err = longint'($signed(word_at(i + int'(pos))));
          pos = pos + 4;
          if (pos + 4 > e) begin
            st = ST_INFO;
          end else begin
            inl = longint'($signed(word_at(i + int'(pos))));
            if (inl < 0) st = ST_INFO;
          end
        end
      end
    end
    if (st == ST_OK) begin
      dl = longint'(len) - idl - mel - inl - 26;
      if (dl < 0) begin
        st = ST_DATA_NEG;
        dl = 0;
      end
    end
    d.offset = 10'((rd_ptr + i) % WIN);
    d.flen = 11'(len);
    d.idl = clamp_len(idl);
    d.mel = clamp_len(mel);
    d.err = 32'(err);
    d.inl = clamp_len(inl);
    d.dl = 11'(dl);
    d.st = st;
    rd_ptr = (rd_ptr + i + len) % WIN;
    fill = fill - (i + len);
    return 1'b1;
  endfunction

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker against the oldest predicted frame.
  always @(posedge clk) begin
    frame_desc_t x;
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame descriptor at offset %0d", frame_offset);
        fail_count++;
      end else begin
        x = pending_frames.pop_front();
        frames_seen++;
        if (frame_offset !== x.offset) begin
          $error("frame_offset exp %0d got %0d", x.offset, frame_offset); fail_count++;
        end
        if (frame_len !== x.flen) begin
          $error("frame_len exp %0d got %0d", x.flen, frame_len); fail_count++;
        end
        if (id_len !== x.idl) begin
          $error("id_len exp %0d got %0d", x.idl, id_len); fail_count++;
        end
        if (method_len !== x.mel) begin
          $error("method_len exp %0d got %0d", x.mel, method_len); fail_count++;
        end
        if (error_code !== x.err) begin
          $error("error_code exp %h got %h", x.err, error_code); fail_count++;
        end
        if (info_len !== x.inl) begin
          $error("info_len exp %0d got %0d", x.inl, info_len); fail_count++;
        end
        if (data_len !== x.dl) begin
          $error("data_len exp %0d got %0d", x.dl, data_len); fail_count++;
        end
        if (status !== x.st) begin
          $error("status exp %0d got %0d", x.st, status); fail_count++;
        end
      end
    end
  end

  // Appends one byte to the stream that is waiting to be sent.
  function automatic void add_byte(logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  // Sends one byte request, with a random gap before it.
  task automatic send_byte(logic [7:0] b);
    frame_desc_t d;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (predict_frame(b, d)) pending_frames = {pending_frames, d};
  endtask

  task automatic send_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front());
  endtask

  // Holds the sender until every predicted frame has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // Register write, only issued once the block has gone quiet.
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_START_MARKER) start_mk = val;
    else if (idx == REG_END_MARKER) end_mk = val;
  endtask

  function automatic void push_word(logic [31:0] w);
    add_byte(w[31:24]);
    add_byte(w[23:16]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endfunction

  function automatic void push_fill(int n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  // Builds a frame with the given sizes; header values may lie about them.
  function automatic void build_frame(int n_id, int n_me, int n_info, int n_data,
                                      logic [31:0] id_f, logic [31:0] me_f,
                                      logic [31:0] info_f, logic [31:0] err,
                                      logic [7:0] last);
    int total;
    total = 26 + n_id + n_me + n_info + n_data;
    add_byte(start_mk);
    push_word(32'(total));
    push_word(id_f);
    push_fill(n_id);
    push_word(me_f);
    push_fill(n_me);
    push_word(err);
    push_word(info_f);
    push_fill(n_info);
    push_fill(n_data);
    push_word($urandom);
    add_byte(last);
  endfunction

  function automatic void good_frame(int n_id, int n_me, int n_info, int n_data,
                                     logic [31:0] err);
    build_frame(n_id, n_me, n_info, n_data, n_id, n_me, n_info, err, end_mk);
  endfunction

  // Noise byte that is never a start marker.
  function automatic logic [7:0] quiet_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == start_mk) b = ~b;
    return b;
  endfunction

  task automatic test_frame_shapes();
    good_frame(0, 0, 0, 0, 32'h0);
    good_frame(3, 5, 2, 7, 32'h8000_0000);
    good_frame(1, 1, 1, 1, 32'h7FFF_FFFF);
    good_frame(2, 0, 4, 0, 32'hFFFF_FFFF);
    send_stream();
    // One long frame with a large payload.
    good_frame(0, 0, 0, 100, $urandom);
    send_stream();
  endtask

  task automatic test_header_errors();
    // Too short for the id length field.
    add_byte(start_mk);
    push_word(32'd8);
    add_byte(quiet_byte());
    add_byte(quiet_byte());
    add_byte(end_mk);
    // Oversized and negative id length.
    build_frame(2, 2, 2, 2, 32'd2000, 2, 2, $urandom, end_mk);
    build_frame(2, 2, 2, 2, 32'hFFFF_FFFB, 2, 2, $urandom, end_mk);
    // Method length runs past the end, then negative.
    build_frame(1, 2, 0, 0, 1, 32'd900, 0, $urandom, end_mk);
    build_frame(1, 2, 0, 0, 1, 32'h8000_0000, 0, $urandom, end_mk);
    // Negative info length.
    build_frame(0, 0, 3, 0, 0, 0, 32'hFFFF_FFFF, $urandom, end_mk);
    // Info length that fits the header but leaves negative data.
    build_frame(0, 0, 0, 4, 0, 0, 32'd5000, $urandom, end_mk);
    build_frame(0, 0, 0, 4, 0, 0, 32'd10, $urandom, end_mk);
    send_stream();
  endtask

  task automatic test_bad_lengths();
    // Lengths below 2 and above the window are skipped, as is a wrong end byte.
    add_byte(start_mk);
    push_word(32'd1);
    add_byte(start_mk);
    push_word(32'hFFFF_FFFF);
    add_byte(start_mk);
    push_word(32'(WIN + 1));
    build_frame(1, 1, 1, 1, 1, 1, 1, $urandom, ~end_mk);
    good_frame(1, 0, 0, 2, $urandom);
    send_stream();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_START_MARKER, 8'hFF);
    write_reg(REG_END_MARKER, 8'h00);
    write_reg(2'd2, 8'h5A);
    write_reg(2'd3, 8'hA5);
    // With a zero end marker a two-byte frame closes on the length field.
    add_byte(start_mk);
    push_word(32'd2);
    good_frame(2, 1, 0, 3, $urandom);
    send_stream();
    write_reg(REG_START_MARKER, 8'h00);
    write_reg(REG_END_MARKER, 8'hFF);
    good_frame(0, 2, 1, 0, $urandom);
    send_stream();
  endtask

  // Mostly well-formed frames with random content, some noise and damage.
  task automatic random_phase(int min_bytes, int min_frames);
    int b0, f0, kind;
    b0 = bytes_sent;
    f0 = frames_seen + pending_frames.size();
    while (bytes_sent - b0 < min_bytes ||
           frames_seen + pending_frames.size() - f0 < min_frames) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          good_frame($urandom_range(4), $urandom_range(4), $urandom_range(4),
                     $urandom_range(8), $urandom);
        end
        6: begin
          build_frame($urandom_range(3), $urandom_range(3), $urandom_range(3),
                      $urandom_range(6), $urandom_range(40) - 8,
                      $urandom_range(40) - 8, $urandom_range(60) - 8, $urandom,
                      end_mk);
        end
        7: begin
          build_frame(1, 1, 1, $urandom_range(4), 1, 1, 1, $urandom, 8'($urandom));
        end
        8: begin
          push_fill($urandom_range(1, 6));
        end
        default: begin
          add_byte(start_mk);
          push_word($urandom);
        end
      endcase
      send_stream();
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 30;
    recv_idle_pct = 53;
    random_phase(70, 2);
    wait_drained();
    write_reg(REG_START_MARKER, 8'($urandom));
    write_reg(REG_END_MARKER, 8'($urandom));
    send_idle_pct = 53;
    recv_idle_pct = 30;
    random_phase(70, 2);
    write_reg(REG_START_MARKER, START_RESET);
    write_reg(REG_END_MARKER, END_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(70, 2);
  endtask

  initial begin
    rd_ptr = 0;
    wr_ptr = 0;
    fill = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 53;
    test_frame_shapes();
    test_header_errors();
    test_bad_lengths();
    test_register_extremes();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes and checked %0d frame descriptors across", bytes_sent,
             frames_seen);
    $display("directed header errors, skipped candidates and several marker settings.");
    if (fail_count == 0) begin
      $display("rpc_frame_deframer_core_tb OK");
    end else begin
      $display("rpc_frame_deframer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
